/* sv/mrib_pkg.sv */
// mrib_pkg: shared widths, register indexes, access codes and request types
// for the rectangle invert blitter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrib_pkg;

	localparam int ADDR_W      = 24;
	localparam int WORD_W      = 16;
	localparam int BIT_IDX_W   = 4;
	localparam int COL_W       = 12;
	localparam int ROW_W       = 13;
	localparam int PITCH_W     = 9;
	localparam int WIR_W       = COL_W - BIT_IDX_W;
	localparam int PROD_W      = COL_W + PITCH_W;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_XS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_XE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_YS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd5;

	// reset values of the registers
	localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd40;
	localparam logic [ROW_W-1:0]   ROWS_RESET  = 13'd1;

	// input kinds and access codes
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;
	localparam logic ACC_READ   = 1'b0;
	localparam logic ACC_WRITE  = 1'b1;

	localparam logic [WORD_W-1:0] WORD_ONES = 16'hffff;

	typedef struct packed {
		logic              access;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] write_data;
		logic              last;
	} mrib_req_t;

	// up to two requests produced by one processed beat
	typedef struct packed {
		logic [1:0] count;
		mrib_req_t  first;
		mrib_req_t  second;
	} mrib_push_t;

endpackage

`default_nettype wire

/* sv/mrib_front.sv */
// mrib_front: input beat capture, configuration registers and the walk
// over the rectangle; emits up to two requests per beat. Uses mrib_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrib_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [mrib_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrib_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            kind,
	input  wire logic [mrib_pkg::WORD_W-1:0]     read_data,
	input  wire logic [mrib_pkg::QCNT_W-1:0]     q_count,
	output mrib_pkg::mrib_push_t                 push
);
	import mrib_pkg::*;

	logic [ADDR_W-1:0]  base_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [COL_W-1:0]   x_start_q;
	logic [COL_W-1:0]   x_end_q;
	logic [COL_W-1:0]   y_start_q;
	logic [ROW_W-1:0]   row_count_q;
	logic [PROD_W-1:0]  prod_q;

	logic               valid_s1;
	logic               kind_s1;
	logic [WORD_W-1:0]  data_s1;

	logic               busy_q, busy_d;
	logic [ROW_W-1:0]   rows_q, rows_d;
	logic [WIR_W-1:0]   word_q, word_d;
	logic [ADDR_W-1:0]  row_addr_q, row_addr_d;
	logic [ADDR_W-1:0]  cur_addr_q, cur_addr_d;

	logic [QCNT_W:0]    reserved;
	logic               accept;
	logic [ADDR_W-1:0]  start_addr;
	logic               empty_rect;
	logic [WIR_W-1:0]   last_idx;
	logic               row_end;
	logic [WORD_W-1:0]  head_mask;
	logic [BIT_IDX_W:0] tail_shift;
	logic [WORD_W-1:0]  tail_mask;
	logic [WORD_W-1:0]  mask;
	logic [ROW_W-1:0]   rows_dec;
	logic [ADDR_W-1:0]  next_row_addr;
	logic [ADDR_W-1:0]  next_word_addr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			pitch_q     <= PITCH_RESET;
			x_start_q   <= '0;
			x_end_q     <= '0;
			y_start_q   <= '0;
			row_count_q <= ROWS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BASE:  base_q      <= cfg_data[ADDR_W-1:0];
				REG_PITCH: pitch_q     <= cfg_data[PITCH_W-1:0];
				REG_XS:    x_start_q   <= cfg_data[COL_W-1:0];
				REG_XE:    x_end_q     <= cfg_data[COL_W-1:0];
				REG_YS:    y_start_q   <= cfg_data[COL_W-1:0];
				REG_ROWS:  row_count_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// line offset of the top row, registered from the y start and pitch registers
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(y_start_q) * PROD_W'(pitch_q);
	end

	// accept only with room for this beat and the one in flight
	assign reserved = {1'b0, q_count} + (valid_s1 ? (QCNT_W+1)'(2) : (QCNT_W+1)'(0));
	assign in_ready = !cfg_write && (reserved <= (QCNT_W+1)'(QUEUE_DEPTH - 2));
	assign accept   = in_valid && in_ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			data_s1 <= read_data;
		end
	end

	// geometry and masks
	assign start_addr = base_q + ADDR_W'(x_start_q[COL_W-1:BIT_IDX_W]) + ADDR_W'(prod_q);
	assign empty_rect = (x_end_q < x_start_q) || (row_count_q == '0);
	assign last_idx   = x_end_q[COL_W-1:BIT_IDX_W] - x_start_q[COL_W-1:BIT_IDX_W];
	assign row_end    = (word_q == last_idx);
	assign head_mask  = WORD_ONES >> x_start_q[BIT_IDX_W-1:0];
	assign tail_shift = {1'b0, x_end_q[BIT_IDX_W-1:0]} + (BIT_IDX_W+1)'(1);
	assign tail_mask  = ~(WORD_ONES >> tail_shift);
	assign mask       = ((word_q == '0) ? head_mask : WORD_ONES)
		& (row_end ? tail_mask : WORD_ONES);
	assign rows_dec       = rows_q - ROW_W'(1);
	assign next_row_addr  = row_addr_q + ADDR_W'(pitch_q);
	assign next_word_addr = cur_addr_q + ADDR_W'(1);

	// walk state update and request generation
	always_comb begin
		busy_d     = busy_q;
		rows_d     = rows_q;
		word_d     = word_q;
		row_addr_d = row_addr_q;
		cur_addr_d = cur_addr_q;
		push       = '0;
		if (valid_s1) begin
			if (kind_s1 == KIND_START) begin
				busy_d = 1'b0;
				if (!empty_rect) begin
					busy_d                  = 1'b1;
					row_addr_d              = start_addr;
					cur_addr_d              = start_addr;
					rows_d                  = row_count_q;
					word_d                  = '0;
					push.count              = 2'd1;
					push.first.access       = ACC_READ;
					push.first.address      = start_addr;
				end
			end else if (busy_q) begin
				push.first.access     = ACC_WRITE;
				push.first.address    = cur_addr_q;
				push.first.write_data = data_s1 ^ mask;
				push.second.access    = ACC_READ;
				if (row_end) begin
					rows_d = rows_dec;
					if (rows_dec == '0) begin
						busy_d          = 1'b0;
						push.count      = 2'd1;
						push.first.last = 1'b1;
					end else begin
						row_addr_d          = next_row_addr;
						cur_addr_d          = next_row_addr;
						word_d              = '0;
						push.count          = 2'd2;
						push.second.address = next_row_addr;
					end
				end else begin
					cur_addr_d          = next_word_addr;
					word_d              = word_q + WIR_W'(1);
					push.count          = 2'd2;
					push.second.address = next_word_addr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rows_q     <= '0;
			word_q     <= '0;
			row_addr_q <= '0;
			cur_addr_q <= '0;
		end else begin
			busy_q     <= busy_d;
			rows_q     <= rows_d;
			word_q     <= word_d;
			row_addr_q <= row_addr_d;
			cur_addr_q <= cur_addr_d;
		end
	end

	// a pair is always a write followed by the next read
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.first.access == ACC_WRITE
			&& push.second.access == ACC_READ && !push.first.last))
		else $error("request pair out of order");

endmodule

`default_nettype wire

/* sv/mrib_queue.sv */
// mrib_queue: short request queue between front and back, taking up to
// two entries and giving one per cycle while popped. Uses mrib_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrib_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mrib_pkg::mrib_push_t        push,
	input  wire logic                        pop,
	output logic [mrib_pkg::QCNT_W-1:0]      count,
	output mrib_pkg::mrib_req_t              head
);
	import mrib_pkg::*;

	mrib_req_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	assign count = count_q;
	assign head  = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((QCNT_W+1)'(count_q) + (QCNT_W+1)'(push.count) - (QCNT_W+1)'(pop))
			<= (QCNT_W+1)'(QUEUE_DEPTH))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("request queue popped while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two requests pushed");

endmodule

`default_nettype wire

/* sv/mrib_back.sv */
// mrib_back: output register of the request channel, refilled from the
// queue head, if any, whenever it is empty or its beat is taken. Uses mrib_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrib_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [mrib_pkg::QCNT_W-1:0] q_count,
	input  wire mrib_pkg::mrib_req_t         head,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output mrib_pkg::mrib_req_t              out_req
);
	import mrib_pkg::*;

	logic      out_valid_q;
	mrib_req_t out_req_q;

	// take the head when the register is free or being drained
	assign pop = (q_count != '0) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= pop || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_req_q <= head;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

endmodule

`default_nettype wire

/* sv/mono_rect_invert_blit_unit.sv */
// Rectangle invert blitter on a 1 bpp framebuffer of 16-bit words.
// Input channel (in_valid/in_ready): kind 0 starts a rectangle, kind 1 brings
// back a word that was read. Output channel (out_valid/out_ready): memory
// requests, a read (access 0) or a write of the inverted word (access 1);
// last marks the final write of the rectangle.
// A start beat gives one read request; each data beat gives its write and,
// unless it finished the rectangle, the next read. Empty rectangles and
// data while idle give nothing.
// Each beat passes the input register; its requests pass the queue and then the
// output register. Input beats can be taken every cycle while in_ready is high;
// the output port gives one request per cycle while out_ready is high, so a long
// run of data beats is paced by the single output register draining the 8-entry queue.
// in_ready drops in a cycle with cfg_write high and whenever the queue cannot
// hold the results of the next beat; a stalled receiver fills the queue and
// then holds off input. Configuration is to be written by the user only while
// idle, after the last beat; the block itself does not enforce this. Reset
// clears the registers to their defaults, the walk state and the queue.
// Depends on mrib_pkg, mrib_front, mrib_queue, mrib_back.
`timescale 1ns / 1ps
`default_nettype none

module mono_rect_invert_blit_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [mrib_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrib_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            kind,
	input  wire logic [mrib_pkg::WORD_W-1:0]     read_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 access,
	output logic [mrib_pkg::ADDR_W-1:0]          address,
	output logic [mrib_pkg::WORD_W-1:0]          write_data,
	output logic                                 last
);
	import mrib_pkg::*;

	mrib_push_t         push;
	logic [QCNT_W-1:0]  q_count;
	mrib_req_t          head;
	logic               pop;
	mrib_req_t          out_req;

	mrib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.read_data (read_data),
		.q_count   (q_count),
		.push      (push)
	);

	mrib_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.count  (q_count),
		.head   (head)
	);

	mrib_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_count   (q_count),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

	assign access     = out_req.access;
	assign address    = out_req.address;
	assign write_data = out_req.write_data;
	assign last       = out_req.last;

endmodule

`default_nettype wire

/* test/blit_request_checker.sv */
`timescale 1ns / 1ps
// blit_request_checker: follows the register port and both channels of the rectangle
// invert blitter, predicts each memory request and compares it field by field.
// Depends on mrib_pkg.

module blit_request_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [mrib_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrib_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            kind,
	input  logic [mrib_pkg::WORD_W-1:0]     read_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            access,
	input  logic [mrib_pkg::ADDR_W-1:0]     address,
	input  logic [mrib_pkg::WORD_W-1:0]     write_data,
	input  logic                            last,
	output int                              mismatch_count,
	output int                              requests_outstanding
);
	import mrib_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// shadow copies of the geometry registers
	logic [ADDR_W-1:0]  base_addr;
	logic [PITCH_W-1:0] pitch;
	logic [COL_W-1:0]   x_first;
	logic [COL_W-1:0]   x_final;
	logic [COL_W-1:0]   y_first;
	logic [ROW_W-1:0]   row_total;

	// rectangle walk state
	logic              walking;
	logic [ROW_W-1:0]  rows_remaining;
	logic [WIR_W-1:0]  word_index;
	logic [ADDR_W-1:0] line_addr;
	logic [ADDR_W-1:0] word_addr;

	mrib_req_t expected_requests[$];
	int        errors = 0;

	function automatic mrib_req_t make_request(input logic acc, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] data, input logic fin);
		mrib_req_t r;
		r.access     = acc;
		r.address    = addr;
		r.write_data = data;
		r.last       = fin;
		return r;
	endfunction

	task automatic log_failure(input string what, input mrib_req_t want, input mrib_req_t got);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("%0t %s: expected acc=%0d addr=%06h data=%04h last=%0d", $time, what,
				want.access, want.address, want.write_data, want.last);
			$display("%0t %s:   actual acc=%0d addr=%06h data=%04h last=%0d", $time, what,
				got.access, got.address, got.write_data, got.last);
		end
	endtask

	// requests caused by one input beat
	task automatic predict_requests(input logic beat_kind, input logic [WORD_W-1:0] fetched);
		logic [WORD_W-1:0] mask;
		logic [WIR_W-1:0]  final_index;
		logic              row_done;
		if (beat_kind == KIND_START) begin
			walking = 1'b0;
			if (x_final < x_first || row_total == '0)
				return;
			line_addr = base_addr + ADDR_W'(x_first >> BIT_IDX_W)
				+ ADDR_W'(y_first) * ADDR_W'(pitch);
			word_addr      = line_addr;
			rows_remaining = row_total;
			word_index     = '0;
			walking        = 1'b1;
			expected_requests.push_back(make_request(ACC_READ, word_addr, '0, 1'b0));
			return;
		end
		// data while idle is dropped
		if (!walking)
			return;
		final_index = WIR_W'((x_final >> BIT_IDX_W) - (x_first >> BIT_IDX_W));
		row_done    = (word_index == final_index);
		mask        = WORD_ONES;
		if (word_index == '0)
			mask &= WORD_ONES >> x_first[BIT_IDX_W-1:0];
		if (row_done)
			mask &= ~(WORD_ONES >> (5'(x_final[BIT_IDX_W-1:0]) + 5'd1));
		if (row_done) begin
			rows_remaining = rows_remaining - 1'b1;
			if (rows_remaining == '0) begin
				expected_requests.push_back(make_request(ACC_WRITE, word_addr,
					fetched ^ mask, 1'b1));
				walking = 1'b0;
				return;
			end
			expected_requests.push_back(make_request(ACC_WRITE, word_addr, fetched ^ mask, 1'b0));
			line_addr  = line_addr + ADDR_W'(pitch);
			word_addr  = line_addr;
			word_index = '0;
		end else begin
			expected_requests.push_back(make_request(ACC_WRITE, word_addr, fetched ^ mask, 1'b0));
			word_addr  = word_addr + 1'b1;
			word_index = word_index + 1'b1;
		end
		expected_requests.push_back(make_request(ACC_READ, word_addr, '0, 1'b0));
	endtask

	// register writes, input beats and request beats as seen at each edge
	always @(posedge clk) begin : monitor
		mrib_req_t got;
		mrib_req_t want;
		if (!arst_n) begin
			base_addr      = '0;
			pitch          = PITCH_RESET;
			x_first        = '0;
			x_final        = '0;
			y_first        = '0;
			row_total      = ROWS_RESET;
			walking        = 1'b0;
			rows_remaining = '0;
			word_index     = '0;
			line_addr      = '0;
			word_addr      = '0;
			expected_requests.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_BASE:  base_addr = cfg_data[ADDR_W-1:0];
					REG_PITCH: pitch     = cfg_data[PITCH_W-1:0];
					REG_XS:    x_first   = cfg_data[COL_W-1:0];
					REG_XE:    x_final   = cfg_data[COL_W-1:0];
					REG_YS:    y_first   = cfg_data[COL_W-1:0];
					REG_ROWS:  row_total = cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_requests(kind, read_data);
			if (out_valid && out_ready) begin
				got = {access, address, write_data, last};
				if (expected_requests.size() == 0) begin
					log_failure("unexpected request", '0, got);
				end else begin
					want = expected_requests.pop_front();
					if (got.access !== want.access || got.address !== want.address ||
							got.write_data !== want.write_data || got.last !== want.last)
						log_failure("request mismatch", want, got);
				end
			end
		end
		mismatch_count       <= errors;
		requests_outstanding <= expected_requests.size();
	end

endmodule

/* test/tb_mono_rect_invert_blit_unit.sv */
`timescale 1ns / 1ps
// tb_mono_rect_invert_blit_unit: rectangle stimulus, memory-side receiver and verdict
// for the rectangle invert blitter; requests are checked by blit_request_checker.
// Depends on mrib_pkg, mono_rect_invert_blit_unit and blit_request_checker.

module tb_mono_rect_invert_blit_unit;
	import mrib_pkg::*;

	localparam int TARGET_BEATS   = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 4;
	localparam int COL_MAX        = (1 << COL_W) - 1;

	typedef struct {
		logic [ADDR_W-1:0]  base;
		logic [PITCH_W-1:0] pitch;
		logic [COL_W-1:0]   x_first;
		logic [COL_W-1:0]   x_final;
		logic [COL_W-1:0]   y_first;
		logic [ROW_W-1:0]   rows;
	} rect_geom_t;

	typedef enum {PH_FULL, PH_CUT, PH_RESTART} phase_kind_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BASE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  kind      = KIND_START;
	logic [WORD_W-1:0]     read_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  access;
	logic [ADDR_W-1:0]     address;
	logic [WORD_W-1:0]     write_data;
	logic                  last;

	int mismatch_count;
	int requests_outstanding;
	int live_beats    = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	bit no_gaps       = 1'b0;

	always #5 clk = ~clk;

	mono_rect_invert_blit_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.read_data  (read_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.access     (access),
		.address    (address),
		.write_data (write_data),
		.last       (last)
	);

	blit_request_checker request_check (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write            (cfg_write),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.kind                 (kind),
		.read_data            (read_data),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.access               (access),
		.address              (address),
		.write_data           (write_data),
		.last                 (last),
		.mismatch_count       (mismatch_count),
		.requests_outstanding (requests_outstanding)
	);

	// memory side: random stalls, or a long hold-off when the sender asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			out_ready    <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			out_ready <= no_gaps || ($urandom_range(0, 99) >= 28);
		end
	end

	// ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (cfg_write || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL mono_rect_invert_blit_unit");
		$finish;
	end

	function automatic int rect_words(input rect_geom_t g);
		if (g.x_final < g.x_first || g.rows == '0)
			return 0;
		return (int'(g.x_final >> BIT_IDX_W) - int'(g.x_first >> BIT_IDX_W) + 1) * int'(g.rows);
	endfunction

	function automatic rect_geom_t random_geom(input int max_span, input int max_rows);
		rect_geom_t g;
		int         span;
		g.base    = ADDR_W'($urandom);
		g.pitch   = PITCH_W'($urandom);
		g.y_first = COL_W'($urandom);
		g.x_first = COL_W'($urandom);
		span      = $urandom_range(0, max_span);
		if (int'(g.x_first) + span > COL_MAX)
			g.x_final = COL_W'(COL_MAX);
		else
			g.x_final = COL_W'(int'(g.x_first) + span);
		g.rows = ROW_W'($urandom_range(1, max_rows));
		return g;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic program_geometry(input rect_geom_t g);
		write_reg(REG_BASE, g.base);
		write_reg(REG_PITCH, g.pitch);
		write_reg(REG_XS, g.x_first);
		write_reg(REG_XE, g.x_final);
		write_reg(REG_YS, g.y_first);
		write_reg(REG_ROWS, g.rows);
		cfg_write <= 1'b0;
	endtask

	// one input beat, with an occasional idle gap in front of it
	task automatic send_beat(input logic k, input logic [WORD_W-1:0] d, input bit counts);
		if (!no_gaps && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		read_data <= d;
		do @(posedge clk); while (!in_ready);
		if (counts)
			live_beats++;
	endtask

	// stop offering and wait for every predicted request, then let the pipe go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (requests_outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input rect_geom_t g, input phase_kind_t how, input int noise);
		int words;
		int part;
		words = rect_words(g);
		program_geometry(g);
		send_beat(KIND_START, WORD_W'($urandom), words != 0);
		// abandon part way through and start the same rectangle over
		if (how == PH_RESTART && words > 1) begin
			part = (words - 1 > 8) ? 8 : words - 1;
			repeat ($urandom_range(1, part)) send_beat(KIND_DATA, WORD_W'($urandom), 1'b1);
			send_beat(KIND_START, WORD_W'($urandom), 1'b1);
		end
		// leave the walk unfinished; the next start abandons it
		if (how == PH_CUT && words > 0)
			words = $urandom_range(0, ((words > 12) ? 12 : words) - 1);
		repeat (words) send_beat(KIND_DATA, WORD_W'($urandom), 1'b1);
		repeat (noise) send_beat(KIND_DATA, WORD_W'($urandom), 1'b0);
		settle();
	endtask

	initial begin : stimulus
		rect_geom_t g;
		int         pick;
		int         phase;
		int         goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset geometry: one pixel at the origin, all ones then all zeros
		send_beat(KIND_START, '0, 1'b1);
		send_beat(KIND_DATA, WORD_ONES, 1'b1);
		send_beat(KIND_START, WORD_ONES, 1'b1);
		send_beat(KIND_DATA, '0, 1'b1);
		settle();

		// single-word rows with start and end masks combined, then data while idle
		g = '{base: 24'h000100, pitch: 9'd1, x_first: 12'd3, x_final: 12'd12,
			y_first: 12'd5, rows: 13'd2};
		run_phase(g, PH_FULL, 1);

		// top of every field but the x start and the row count, addresses wrap
		g = '{base: 24'hffffff, pitch: 9'h1ff, x_first: 12'd4080, x_final: 12'hfff,
			y_first: 12'hfff, rows: 13'd2};
		run_phase(g, PH_FULL, 0);

		// zero pitch revisits the same line; one-pixel edge masks
		g = '{base: 24'h000000, pitch: 9'd0, x_first: 12'd15, x_final: 12'd16,
			y_first: 12'hfff, rows: 13'd2};
		run_phase(g, PH_FULL, 0);

		// empty rectangles: end left of start, then zero rows
		g = '{base: 24'h000040, pitch: 9'd40, x_first: 12'd100, x_final: 12'd99,
			y_first: 12'd1, rows: 13'd1};
		run_phase(g, PH_FULL, 1);
		g = '{base: 24'h000040, pitch: 9'd40, x_first: 12'd0, x_final: 12'd31,
			y_first: 12'd1, rows: 13'd0};
		run_phase(g, PH_FULL, 0);

		// full-width rectangle with every row, abandoned by a new start
		g = '{base: 24'h123456, pitch: 9'd256, x_first: 12'd0, x_final: 12'hfff,
			y_first: 12'd0, rows: 13'h1fff};
		program_geometry(g);
		send_beat(KIND_START, '0, 1'b1);
		repeat (3) send_beat(KIND_DATA, WORD_W'($urandom), 1'b1);
		settle();
		g = '{base: 24'h000200, pitch: 9'd2, x_first: 12'd17, x_final: 12'd40,
			y_first: 12'd3, rows: 13'd1};
		run_phase(g, PH_FULL, 0);

		// random rectangles
		goal  = live_beats + TARGET_BEATS;
		phase = 0;
		while (live_beats < goal) begin
			phase++;
			no_gaps <= (phase == 4) || (phase >= 12 && phase < 20);
			pick = $urandom_range(0, 99);
			if (phase == 4) begin
				// receiver holds off while a long rectangle keeps coming
				hold_requests <= hold_requests + 1;
				g = random_geom(0, 1);
				g.x_first = COL_W'($urandom_range(0, 15));
				g.x_final = COL_W'(16 * 20 - 1);
				g.rows    = 13'd2;
				run_phase(g, PH_FULL, 0);
			end else if (phase == 9) begin
				g = random_geom(0, 1);
				g.x_first = COL_W'($urandom_range(0, 15));
				g.x_final = COL_W'($urandom_range(COL_MAX - 15, COL_MAX));
				run_phase(g, PH_FULL, 0);
			end else if (pick < 70) begin
				g = random_geom(80, 3);
				run_phase(g, PH_FULL, ($urandom_range(0, 9) == 0) ? 1 : 0);
			end else if (pick < 80) begin
				g = random_geom(200, (1 << ROW_W) - 1);
				run_phase(g, PH_CUT, 0);
			end else if (pick < 90) begin
				g = random_geom(80, 3);
				if (g.x_first == '0 || $urandom_range(0, 1) == 0)
					g.rows = '0;
				else
					g.x_final = COL_W'($urandom_range(0, int'(g.x_first) - 1));
				run_phase(g, PH_FULL, $urandom_range(0, 2));
			end else begin
				g = random_geom(80, 3);
				run_phase(g, PH_RESTART, 0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && requests_outstanding == 0)
			$display("PASS mono_rect_invert_blit_unit");
		else
			$display("FAIL mono_rect_invert_blit_unit");
		$finish;
	end

endmodule
